// ===== rtl/hir_pkg.sv =====
// Shared types and constants for the hashed id registry.
// Request/response structs, status codes, sequencer states, hash multiplier.
// No dependencies.
`default_nettype none

package hir_pkg;

    // Default sizes of the slot store and the bucket table
    localparam int DEF_SLOTS   = 16;
    localparam int DEF_BUCKETS = 32;

    // Field widths fixed by the interface
    localparam int ID_W       = 16;
    localparam int DATA_W     = 32;
    localparam int LIMIT_W    = 5;
    localparam int SLOT_OUT_W = 4;

    // Knuth multiplicative hash constant
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    // Capacity register value after reset
    localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RST = 5'd16;

    typedef enum logic {
        OP_FIND     = 1'b0,
        OP_REGISTER = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_BKT,
        S_CHK_BKT,
        S_CHK_KEY,
        S_DONE
    } t_state;

    typedef struct packed {
        t_opcode             opcode;
        logic [ID_W-1:0]     key_id;
        logic [DATA_W-1:0]   entry_data;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_OUT_W-1:0]   slot_number;
        logic [DATA_W-1:0]       found_data;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/hir_bucket_mem.sv =====
// Bucket table memory: one write port, one registered read port.
// Each word holds a valid bit on top of a slot index. Uses no package items.
`default_nettype none

module hir_bucket_mem #(
    parameter int BUCKETS = 32,
    parameter int SW      = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [$clog2(BUCKETS)-1:0]  i_waddr,
    input  wire logic [SW:0]                 i_wdata,
    input  wire logic [$clog2(BUCKETS)-1:0]  i_raddr,
    output logic      [SW:0]                 o_rdata
);

    logic [SW:0] r_mem [BUCKETS];
    logic [SW:0] r_rdata;

    // Write on request; the read data is registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/hir_slot_mem.sv =====
// Dense slot store: id key and payload per slot, one write, one registered read.
// Depends on hir_pkg for field widths.
`default_nettype none

module hir_slot_mem
    import hir_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS,
    parameter int SW    = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [SW-1:0]     i_waddr,
    input  wire logic [ID_W-1:0]   i_wkey,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [SW-1:0]     i_raddr,
    output logic      [ID_W-1:0]   o_rkey,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [ID_W-1:0]   r_keys [SLOTS];
    logic [DATA_W-1:0] r_data [SLOTS];
    logic [ID_W-1:0]   r_rkey;
    logic [DATA_W-1:0] r_rdata;

    // Append on register, read key and payload together
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_keys[i_waddr] <= i_wkey;
            r_data[i_waddr] <= i_wdata;
        end
        r_rkey  <= r_keys[i_raddr];
        r_rdata <= r_data[i_raddr];
    end

    assign o_rkey  = r_rkey;
    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/hir_ctrl.sv =====
// Probe sequencer: hash, linear probe walk, insert, result register.
// Depends on hir_pkg; drives the bucket and slot memories.
`default_nettype none

module hir_ctrl
    import hir_pkg::*;
#(
    parameter int SLOTS   = DEF_SLOTS,
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int SW      = 4,
    parameter int CW      = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [LIMIT_W-1:0]          i_slot_limit,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire t_req                        i_in_req,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output t_rsp                             o_out_rsp,
    output logic [CW-1:0]                    o_entry_count,
    output logic                             o_bkt_we,
    output logic [$clog2(BUCKETS)-1:0]       o_bkt_waddr,
    output logic [SW:0]                      o_bkt_wdata,
    output logic [$clog2(BUCKETS)-1:0]       o_bkt_raddr,
    input  wire logic [SW:0]                 i_bkt_rdata,
    output logic                             o_slot_we,
    output logic [SW-1:0]                    o_slot_waddr,
    output logic [ID_W-1:0]                  o_slot_wkey,
    output logic [DATA_W-1:0]                o_slot_wdata,
    output logic [SW-1:0]                    o_slot_raddr,
    input  wire logic [ID_W-1:0]             i_slot_rkey,
    input  wire logic [DATA_W-1:0]           i_slot_rdata
);

    localparam int          BW       = $clog2(BUCKETS);
    localparam logic [BW-1:0] BKT_MASK = BW'(BUCKETS - 1);
    localparam logic [BW-1:0] BKT_LAST = BW'(BUCKETS - 1);
    localparam int          LW       = (CW > LIMIT_W) ? CW : LIMIT_W;

    t_state              r_state,  n_state;
    t_opcode             r_op,     n_op;
    logic [ID_W-1:0]     r_id,     n_id;
    logic [DATA_W-1:0]   r_data,   n_data;
    logic [BW-1:0]       r_bkt,    n_bkt;
    logic [BW-1:0]       r_probe,  n_probe;
    logic [BW-1:0]       r_clr,    n_clr;
    logic [SW-1:0]       r_slot,   n_slot;
    logic [CW-1:0]       r_count,  n_count;
    t_rsp                r_res,    n_res;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out,    n_out;

    logic [31:0]         w_prod;
    logic [BW-1:0]       w_hash;
    logic [LW-1:0]       w_cap;
    logic [LW-1:0]       w_lim;
    logic [LW-1:0]       w_cnt;
    logic                w_full;

    // Widen a slot index and keep the low output bits
    function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SW-1:0] s);
        logic [SW+SLOT_OUT_W-1:0] t;
        t = {{SLOT_OUT_W{1'b0}}, s};
        return t[SLOT_OUT_W-1:0];
    endfunction

    // Hash of the incoming id: low bits of the 32-bit product, masked
    assign w_prod = {16'd0, i_in_req.key_id} * HASH_MULT;
    assign w_hash = w_prod[BW-1:0] & BKT_MASK;

    // Effective capacity is the smaller of the register and the store depth
    assign w_lim  = LW'(i_slot_limit);
    assign w_cnt  = LW'(r_count);
    assign w_cap  = (w_lim < LW'(SLOTS)) ? w_lim : LW'(SLOTS);
    assign w_full = (w_cnt >= w_cap);

    // Memory read addresses follow the probe pointer and the bucket word
    assign o_bkt_raddr  = r_bkt;
    assign o_slot_raddr = i_bkt_rdata[SW-1:0];

    assign o_slot_waddr = r_count[SW-1:0];
    assign o_slot_wkey  = r_id;
    assign o_slot_wdata = r_data;

    // Next state and memory controls
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_data      = r_data;
        n_bkt       = r_bkt;
        n_probe     = r_probe;
        n_clr       = r_clr;
        n_slot      = r_slot;
        n_count     = r_count;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_bkt_we    = 1'b0;
        o_bkt_waddr = r_bkt;
        o_bkt_wdata = '0;
        o_slot_we   = 1'b0;
        o_in_ready  = (r_state == S_IDLE);

        // Drop the result once the consumer takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // Mark every bucket empty after reset
            S_CLEAR: begin
                o_bkt_we    = 1'b1;
                o_bkt_waddr = r_clr;
                n_clr       = r_clr + 1'b1;
                if (r_clr == BKT_LAST) begin
                    n_state = S_IDLE;
                end
            end

            // Capture the request and its home bucket; a zero id is answered as invalid
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_req.opcode;
                    n_id    = i_in_req.key_id;
                    n_data  = i_in_req.entry_data;
                    n_bkt   = w_hash;
                    n_probe = '0;
                    if (i_in_req.key_id == '0) begin
                        n_res   = '{status: ST_INVALID, slot_number: '0, found_data: '0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RD_BKT;
                    end
                end
            end

            S_RD_BKT: begin
                n_state = S_CHK_BKT;
            end

            // Empty bucket ends the run; insert here on a register
            S_CHK_BKT: begin
                if (!i_bkt_rdata[SW]) begin
                    n_state = S_DONE;
                    if (r_op == OP_FIND) begin
                        n_res = '{status: ST_NOT_FOUND, slot_number: '0, found_data: '0};
                    end else if (w_full) begin
                        n_res = '{status: ST_FULL, slot_number: '0, found_data: '0};
                    end else begin
                        o_bkt_we    = 1'b1;
                        o_bkt_wdata = {1'b1, r_count[SW-1:0]};
                        o_slot_we   = 1'b1;
                        n_count     = r_count + 1'b1;
                        n_res       = '{status: ST_OK, slot_number: slot_out(r_count[SW-1:0]),
                                        found_data: '0};
                    end
                end else begin
                    n_slot  = i_bkt_rdata[SW-1:0];
                    n_state = S_CHK_KEY;
                end
            end

            // Compare the stored key, end after a full lap, else advance to the next bucket
            S_CHK_KEY: begin
                if (i_slot_rkey == r_id) begin
                    n_state = S_DONE;
                    if (r_op == OP_FIND) begin
                        n_res = '{status: ST_OK, slot_number: slot_out(r_slot),
                                  found_data: i_slot_rdata};
                    end else begin
                        n_res = '{status: ST_DUPLICATE, slot_number: '0, found_data: '0};
                    end
                end else if (r_probe == BKT_LAST) begin
                    n_state = S_DONE;
                    if (r_op == OP_FIND) begin
                        n_res = '{status: ST_NOT_FOUND, slot_number: '0, found_data: '0};
                    end else begin
                        n_res = '{status: ST_FULL, slot_number: '0, found_data: '0};
                    end
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_bkt   = (r_bkt + 1'b1) & BKT_MASK;
                    n_state = S_RD_BKT;
                end
            end

            // Hand the result to the output register when it is free
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_id    <= n_id;
        r_data  <= n_data;
        r_bkt   <= n_bkt;
        r_probe <= n_probe;
        r_slot  <= n_slot;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_rsp     = r_out;
    assign o_entry_count = r_count;

endmodule

`default_nettype wire

// ===== rtl/hashed_id_registry_top.sv =====
// A request is accepted in the idle state and walks a probe loop: bucket read and bucket
// check per probed bucket, plus a key check when the bucket is in use. The run ends at an
// empty bucket, on a key match or after a full lap of BUCKETS probes. A zero id goes
// straight to the done state. Throughput: one request at a time; the next is accepted
// once its result is registered, which waits while the previous result is not taken.
// Reset (synchronous, active low) clears the count and starts clearing every bucket.
`default_nettype none

module hashed_id_registry_top
    import hir_pkg::*;
#(
    parameter int SLOTS   = DEF_SLOTS,
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [LIMIT_W-1:0] i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_req               i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_rsp                    o_out_rsp
);

    localparam int BW = $clog2(BUCKETS);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [LIMIT_W-1:0] r_slot_limit;
    logic [CW-1:0]      w_entry_count;
    logic               w_bkt_we;
    logic [BW-1:0]      w_bkt_waddr;
    logic [SW:0]        w_bkt_wdata;
    logic [BW-1:0]      w_bkt_raddr;
    logic [SW:0]        w_bkt_rdata;
    logic               w_slot_we;
    logic [SW-1:0]      w_slot_waddr;
    logic [ID_W-1:0]    w_slot_wkey;
    logic [DATA_W-1:0]  w_slot_wdata;
    logic [SW-1:0]      w_slot_raddr;
    logic [ID_W-1:0]    w_slot_rkey;
    logic [DATA_W-1:0]  w_slot_rdata;

    // Capacity register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= SLOT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_slot_limit <= i_cfg_data;
        end
    end

    hir_ctrl #(
        .SLOTS   (SLOTS),
        .BUCKETS (BUCKETS),
        .SW      (SW),
        .CW      (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_slot_limit  (r_slot_limit),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_req      (i_in_req),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_rsp     (o_out_rsp),
        .o_entry_count (w_entry_count),
        .o_bkt_we      (w_bkt_we),
        .o_bkt_waddr   (w_bkt_waddr),
        .o_bkt_wdata   (w_bkt_wdata),
        .o_bkt_raddr   (w_bkt_raddr),
        .i_bkt_rdata   (w_bkt_rdata),
        .o_slot_we     (w_slot_we),
        .o_slot_waddr  (w_slot_waddr),
        .o_slot_wkey   (w_slot_wkey),
        .o_slot_wdata  (w_slot_wdata),
        .o_slot_raddr  (w_slot_raddr),
        .i_slot_rkey   (w_slot_rkey),
        .i_slot_rdata  (w_slot_rdata)
    );

    hir_bucket_mem #(
        .BUCKETS (BUCKETS),
        .SW      (SW)
    ) u_bucket_mem (
        .i_clk   (i_clk),
        .i_we    (w_bkt_we),
        .i_waddr (w_bkt_waddr),
        .i_wdata (w_bkt_wdata),
        .i_raddr (w_bkt_raddr),
        .o_rdata (w_bkt_rdata)
    );

    hir_slot_mem #(
        .SLOTS (SLOTS),
        .SW    (SW)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wkey  (w_slot_wkey),
        .i_wdata (w_slot_wdata),
        .i_raddr (w_slot_raddr),
        .o_rkey  (w_slot_rkey),
        .o_rdata (w_slot_rdata)
    );

`ifndef SYNTHESIS
    // An accepted request leaves the sequencer busy in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while previous one still in flight");

    // The store never holds more entries than it has slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_entry_count <= CW'(SLOTS))
        else $error("entry count exceeds slot store depth");

    // Failed requests carry neither a slot nor data
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_rsp.status != ST_OK))
            |-> (o_out_rsp.slot_number == '0) && (o_out_rsp.found_data == '0))
        else $error("refused request reports slot or data");

    // An entry is added only on an insert
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_entry_count != $past(w_entry_count)) |-> $past(w_slot_we))
        else $error("entry count moved without a slot write");
`endif

endmodule

`default_nettype wire
